/* hw/rtl/polynomial_map_evaluator_defines.svh */
// Assertion macros for the polynomial map evaluator.
// Needs clk and arst_n in the scope of the including module.
`ifndef POLYNOMIAL_MAP_EVALUATOR_DEFINES_SVH
`define POLYNOMIAL_MAP_EVALUATOR_DEFINES_SVH
// same-cycle implication
`define PMEV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PMEV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/pmev_pkg.sv */
// Shared types, codes and Q8.24 arithmetic helpers of the polynomial map evaluator.
// No dependencies.
package pmev_pkg;

	localparam int FRAC_BITS = 24;
	localparam int ROWS = 3;
	localparam int FIXED_CNT_2D = 6;
	localparam int FIXED_CNT_3D = 10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL = 1'b1;
	localparam logic CFG_DIMENSION = 1'b0;
	localparam logic CFG_POLY_ORDER = 1'b1;
	localparam logic [1:0] DIM_3D = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POW,
		ST_TERM,
		ST_DRAIN,
		ST_MERGE
	} state_t;

	typedef enum logic [3:0] {
		M_ONE, M_X, M_Y, M_Z, M_XX, M_YY, M_ZZ, M_XY, M_XZ, M_YZ
	} mono_t;

	typedef struct packed {
		logic               valid;
		logic               first;
		logic               last;
		logic               pass_a;
		logic               pass_b;
		logic               pass_c;
		logic               ov;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
	} term_op_t;

	typedef struct packed {
		logic busy;
		logic load_out;
	} ctrl_stat_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic               ov;
	} fx_t;

	function automatic fx_t fx_sat(input logic signed [63:0] q, input int unsigned effw);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		fx_t r;
		hi = (64'sd1 <<< (effw - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		r.ov = 1'b0;
		r.v = q[31:0];
		if (q > hi) begin
			r.v = hi[31:0];
			r.ov = 1'b1;
		end else if (q < lo) begin
			r.v = lo[31:0];
			r.ov = 1'b1;
		end
		return r;
	endfunction

	function automatic fx_t fx_mul(input logic signed [31:0] a, input logic signed [31:0] b,
		input int unsigned effw);
		logic signed [63:0] p;
		p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
		return fx_sat(p >>> FRAC_BITS, effw);
	endfunction

	function automatic fx_t fx_add(input logic signed [31:0] a, input logic signed [31:0] b,
		input int unsigned effw);
		logic signed [63:0] s;
		s = $signed({{32{a[31]}}, a}) + $signed({{32{b[31]}}, b});
		return fx_sat(s, effw);
	endfunction

	function automatic logic signed [31:0] fx_one(input int unsigned effw);
		fx_t r;
		r = fx_sat(64'sd1 <<< FRAC_BITS, effw);
		return r.v;
	endfunction

	function automatic logic signed [31:0] fx_sext(input logic [31:0] v,
		input int unsigned effw);
		logic [31:0] t;
		t = v << (32 - effw);
		return $signed(t) >>> (32 - effw);
	endfunction

	function automatic logic [31:0] fx_mask(input logic signed [31:0] v,
		input int unsigned effw);
		return v & (32'hFFFF_FFFF >> (32 - effw));
	endfunction

	// quadratic term order for order 2
	function automatic mono_t fixed_mono(input logic three, input logic [3:0] n);
		mono_t m;
		m = M_ONE;
		if (three) begin
			unique case (n)
				4'd0: m = M_ONE;
				4'd1: m = M_X;
				4'd2: m = M_Y;
				4'd3: m = M_Z;
				4'd4: m = M_XX;
				4'd5: m = M_YY;
				4'd6: m = M_ZZ;
				4'd7: m = M_XY;
				4'd8: m = M_XZ;
				4'd9: m = M_YZ;
				default: m = M_ONE;
			endcase
		end else begin
			unique case (n)
				4'd0: m = M_ONE;
				4'd1: m = M_X;
				4'd2: m = M_Y;
				4'd3: m = M_XX;
				4'd4: m = M_YY;
				4'd5: m = M_XY;
				default: m = M_ONE;
			endcase
		end
		return m;
	endfunction

endpackage

/* hw/rtl/pmev_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 84,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/pmev_lane.sv */
// One coordinate lane: coefficient row store, three-multiply term pipeline, saturating sum.
// Depends on pmev_pkg and pmev_ram.
module pmev_lane #(
	parameter int MAX_TERMS = 84,
	parameter int EFF_W = 32,
	localparam int NW = $clog2(MAX_TERMS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [NW-1:0]      wr_addr,
	input  logic signed [31:0] wr_data,
	input  logic [NW-1:0]      rd_addr,
	input  pmev_pkg::term_op_t op,
	output logic signed [31:0] sum,
	output logic               ov,
	output logic               done
);
	import pmev_pkg::*;

	logic [31:0] coef;
	term_op_t op_s1, op_s2, op_s3, op_s4;
	term_op_t nx_s2, nx_s3, nx_s4;
	fx_t m1, m2, m3, ad;
	logic signed [31:0] acc_q;
	logic ov_q, done_q;

	pmev_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (coef)
	);

	always_comb begin
		m1 = fx_mul($signed(coef), op_s1.a, EFF_W);
		m2 = fx_mul(op_s2.a, op_s2.b, EFF_W);
		m3 = fx_mul(op_s3.a, op_s3.c, EFF_W);
		ad = fx_add(op_s4.first ? 32'sd0 : acc_q, op_s4.a, EFF_W);

		nx_s2 = op_s1;
		nx_s2.a = op_s1.pass_a ? $signed(coef) : m1.v;
		nx_s2.ov = op_s1.ov | (!op_s1.pass_a & m1.ov);

		nx_s3 = op_s2;
		nx_s3.a = op_s2.pass_b ? op_s2.a : m2.v;
		nx_s3.ov = op_s2.ov | (!op_s2.pass_b & m2.ov);

		nx_s4 = op_s3;
		nx_s4.a = op_s3.pass_c ? op_s3.a : m3.v;
		nx_s4.ov = op_s3.ov | (!op_s3.pass_c & m3.ov);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
			op_s3 <= '0;
			op_s4 <= '0;
			done_q <= 1'b0;
		end else begin
			op_s1 <= op;
			op_s2 <= nx_s2;
			op_s3 <= nx_s3;
			op_s4 <= nx_s4;
			done_q <= op_s4.valid && op_s4.last;
		end
	end

	always_ff @(posedge clk) begin
		if (op_s4.valid) begin
			acc_q <= ad.v;
			ov_q <= (op_s4.first ? 1'b0 : ov_q) | op_s4.ov | ad.ov;
		end
	end

	assign sum = acc_q;
	assign ov = ov_q;
	assign done = done_q;

endmodule

/* hw/rtl/pmev_ctrl.sv */
// Sequencer: power table build, monomial enumeration and term issue to the lanes.
// Depends on pmev_pkg and polynomial_map_evaluator_defines.svh.
`include "polynomial_map_evaluator_defines.svh"
module pmev_ctrl #(
	parameter int MAX_ORDER = 6,
	parameter int MAX_TERMS = 84,
	parameter int EFF_W = 32,
	localparam int NW = $clog2(MAX_TERMS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 three,
	input  logic [2:0]           poly_order,
	input  logic signed [31:0]   px,
	input  logic signed [31:0]   py,
	input  logic signed [31:0]   pz,
	input  logic                 lane_done,
	input  logic                 out_free,
	output pmev_pkg::term_op_t   op,
	output logic [NW-1:0]        rd_addr,
	output pmev_pkg::ctrl_stat_t stat
);
	import pmev_pkg::*;

	localparam int EW = $clog2(MAX_ORDER + 1);
	localparam int SW = $clog2(MAX_ORDER + 3);

	state_t state_q, state_d;
	logic [SW-1:0] step_q;
	logic [NW-1:0] n_q;
	logic [EW-1:0] ex_q, ey_q, ez_q, ord;
	logic signed [31:0] one;
	logic signed [31:0] bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic signed [31:0] pw_x_q [MAX_ORDER+1];
	logic signed [31:0] pw_y_q [MAX_ORDER+1];
	logic signed [31:0] pw_z_q [MAX_ORDER+1];
	logic pov_x_q [MAX_ORDER+1];
	logic pov_y_q [MAX_ORDER+1];
	logic pov_z_q [MAX_ORDER+1];
	logic [2:0] cov_q;
	logic signed [31:0] sx_q, sy_q, sz_q, xy_q, xz_q, yz_q;
	logic [2:0] sqov_q, crov_q;
	logic signed [31:0] a0, b0, a1, b1, a2, b2;
	fx_t m0, m1, m2;
	logic do_pow, do_sq, pow_last;
	logic fixed, mono_last, last, at_top, yz_top;
	mono_t code;

	assign one = fx_one(EFF_W);
	assign ord = (int'(poly_order) > MAX_ORDER) ? EW'(MAX_ORDER) : EW'(poly_order);
	assign fixed = (ord == EW'(2));

	assign do_pow = (int'(step_q) <= MAX_ORDER);
	assign do_sq = (int'(step_q) == MAX_ORDER + 1);
	assign pow_last = (int'(step_q) == MAX_ORDER + 2);

	always_comb begin
		if (do_pow) begin
			a0 = cx_q; b0 = bx_q; a1 = cy_q; b1 = by_q; a2 = cz_q; b2 = bz_q;
		end else if (do_sq) begin
			a0 = bx_q; b0 = bx_q; a1 = by_q; b1 = by_q; a2 = bz_q; b2 = bz_q;
		end else begin
			a0 = bx_q; b0 = by_q; a1 = bx_q; b1 = bz_q; a2 = by_q; b2 = bz_q;
		end
		m0 = fx_mul(a0, b0, EFF_W);
		m1 = fx_mul(a1, b1, EFF_W);
		m2 = fx_mul(a2, b2, EFF_W);
	end

	assign at_top = ((EW+2)'(ex_q) + (EW+2)'(ey_q) + (EW+2)'(ez_q)) == (EW+2)'(ord);
	assign yz_top = ((EW+1)'(ey_q) + (EW+1)'(ez_q)) == (EW+1)'(ord);
	assign mono_last = three ? (ez_q == ord) : (ey_q == ord);
	assign code = fixed_mono(three, 4'(n_q));

	always_comb begin
		if (fixed) begin
			last = three ? (n_q == NW'(FIXED_CNT_3D - 1)) : (n_q == NW'(FIXED_CNT_2D - 1));
		end else begin
			last = mono_last || (n_q == NW'(MAX_TERMS - 1));
		end
	end

	always_comb begin
		op.valid = 1'b0;
		op.first = (n_q == '0);
		op.last = last;
		op.pass_a = 1'b0;
		op.pass_b = 1'b1;
		op.pass_c = 1'b1;
		op.ov = 1'b0;
		op.a = pw_x_q[ex_q];
		op.b = pw_y_q[ey_q];
		op.c = pw_z_q[ez_q];
		if (fixed) begin
			case (code)
				M_ONE: op.pass_a = 1'b1;
				M_X:   op.a = bx_q;
				M_Y:   op.a = by_q;
				M_Z:   op.a = bz_q;
				M_XX:  begin op.a = sx_q; op.ov = sqov_q[0]; end
				M_YY:  begin op.a = sy_q; op.ov = sqov_q[1]; end
				M_ZZ:  begin op.a = sz_q; op.ov = sqov_q[2]; end
				M_XY:  begin op.a = xy_q; op.ov = crov_q[0]; end
				M_XZ:  begin op.a = xz_q; op.ov = crov_q[1]; end
				M_YZ:  begin op.a = yz_q; op.ov = crov_q[2]; end
				default: op.pass_a = 1'b1;
			endcase
		end else begin
			op.pass_b = 1'b0;
			op.pass_c = !three;
			op.ov = pov_x_q[ex_q] | pov_y_q[ey_q] | (three & pov_z_q[ez_q]);
		end
		op.valid = (state_q == ST_TERM);
	end

	assign rd_addr = n_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_POW;
			ST_POW:   if (pow_last) state_d = ST_TERM;
			ST_TERM:  if (last) state_d = ST_DRAIN;
			ST_DRAIN: if (lane_done) state_d = ST_MERGE;
			ST_MERGE: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != ST_IDLE);
		stat.load_out = (state_q == ST_MERGE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			n_q <= '0;
			ex_q <= '0;
			ey_q <= '0;
			ez_q <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				step_q <= SW'(1);
				n_q <= '0;
				ex_q <= '0;
				ey_q <= '0;
				ez_q <= '0;
			end else if (state_q == ST_POW) begin
				step_q <= step_q + SW'(1);
			end else if (state_q == ST_TERM) begin
				n_q <= n_q + NW'(1);
				if (at_top) begin
					ex_q <= '0;
					if (three && yz_top) begin
						ey_q <= '0;
						ez_q <= ez_q + EW'(1);
					end else begin
						ey_q <= ey_q + EW'(1);
					end
				end else begin
					ex_q <= ex_q + EW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bx_q <= px;
			by_q <= py;
			bz_q <= pz;
			cx_q <= one;
			cy_q <= one;
			cz_q <= one;
			cov_q <= '0;
			pw_x_q[0] <= one;
			pw_y_q[0] <= one;
			pw_z_q[0] <= one;
			pov_x_q[0] <= 1'b0;
			pov_y_q[0] <= 1'b0;
			pov_z_q[0] <= 1'b0;
		end else if (state_q == ST_POW) begin
			if (do_pow) begin
				cx_q <= m0.v;
				cy_q <= m1.v;
				cz_q <= m2.v;
				cov_q <= cov_q | {m2.ov, m1.ov, m0.ov};
				pw_x_q[step_q[EW-1:0]] <= m0.v;
				pw_y_q[step_q[EW-1:0]] <= m1.v;
				pw_z_q[step_q[EW-1:0]] <= m2.v;
				pov_x_q[step_q[EW-1:0]] <= cov_q[0] | m0.ov;
				pov_y_q[step_q[EW-1:0]] <= cov_q[1] | m1.ov;
				pov_z_q[step_q[EW-1:0]] <= cov_q[2] | m2.ov;
			end else if (do_sq) begin
				sx_q <= m0.v;
				sy_q <= m1.v;
				sz_q <= m2.v;
				sqov_q <= {m2.ov, m1.ov, m0.ov};
			end else begin
				xy_q <= m0.v;
				xz_q <= m1.v;
				yz_q <= m2.v;
				crov_q <= {m2.ov, m1.ov, m0.ov};
			end
		end
	end

	`PMEV_ASSERT_NOW(a_start_idle, start, state_q == ST_IDLE, "evaluate request while busy")
	`PMEV_ASSERT_NEXT(a_last_drain, op.valid && op.last, state_q == ST_DRAIN, "issue after last term")
	`PMEV_ASSERT_NEXT(a_load_idle, stat.load_out, state_q == ST_IDLE, "result load did not end item")
	`PMEV_ASSERT_NOW(a_done_drain, lane_done, state_q == ST_DRAIN, "lane finished outside drain")

endmodule

/* hw/rtl/polynomial_map_evaluator.sv */
// Top level of the polynomial map evaluator: config registers, three lanes, result merge.
// Depends on pmev_pkg, pmev_ctrl and pmev_lane.
//
//  port group   handshake               payload
//  cfg          cfg_we                  cfg_index, cfg_data
//  in           in_valid / in_stall     opcode, coef_row, coef_index, coef_value, in_x..in_z
//  out          out_valid / out_stall   out_x, out_y, out_z, overflow
//
// Write request: taken while idle.
// Evaluate request: power table build, then one issued term per monomial
// (6 or 10 at order 2, up to MAX_TERMS otherwise), then the lane pipeline and a merge.
// in_stall is high while an evaluate request is in flight; a finished result waits
// in the output register while new requests are taken.
module polynomial_map_evaluator #(
	parameter int MAX_ORDER = 6,
	parameter int MAX_TERMS = 84,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [2:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [0:0]         opcode,
	input  logic [1:0]         coef_row,
	input  logic [6:0]         coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               overflow
);
	import pmev_pkg::*;

	localparam int EFF_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
	localparam int NW = $clog2(MAX_TERMS);

	logic [1:0] dim_q;
	logic [2:0] ord_q;
	logic three, req, start, wr_ok, out_free, out_valid_q;
	logic signed [31:0] px, py, pz, wdata;
	term_op_t op;
	logic [NW-1:0] rd_addr;
	ctrl_stat_t stat;
	logic signed [31:0] sum [ROWS];
	logic [ROWS-1:0] lov, ldone;

	assign three = (dim_q == DIM_3D);
	assign req = in_valid && !in_stall;
	assign start = req && (opcode == OP_EVAL);
	assign wr_ok = req && (opcode == OP_WRITE) && (int'(coef_row) < ROWS)
		&& (int'(coef_index) < MAX_TERMS);
	assign in_stall = stat.busy;
	assign out_free = !out_valid_q || !out_stall;

	assign px = fx_sext(in_x, EFF_W);
	assign py = fx_sext(in_y, EFF_W);
	assign pz = three ? fx_sext(in_z, EFF_W) : 32'sd0;
	assign wdata = fx_sext(coef_value, EFF_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 2'd2;
			ord_q <= 3'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIMENSION:  dim_q <= cfg_data[1:0];
				CFG_POLY_ORDER: ord_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	pmev_ctrl #(.MAX_ORDER(MAX_ORDER), .MAX_TERMS(MAX_TERMS), .EFF_W(EFF_W)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.three      (three),
		.poly_order (ord_q),
		.px         (px),
		.py         (py),
		.pz         (pz),
		.lane_done  (&ldone),
		.out_free   (out_free),
		.op         (op),
		.rd_addr    (rd_addr),
		.stat       (stat)
	);

	for (genvar r = 0; r < ROWS; r++) begin : g_lane
		pmev_lane #(.MAX_TERMS(MAX_TERMS), .EFF_W(EFF_W)) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_ok && (coef_row == 2'(r))),
			.wr_addr (NW'(coef_index)),
			.wr_data (wdata),
			.rd_addr (rd_addr),
			.op      (op),
			.sum     (sum[r]),
			.ov      (lov[r]),
			.done    (ldone[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// merge: mask to data width, drop the z lane in 2-D
	always_ff @(posedge clk) begin
		if (stat.load_out) begin
			out_x <= $signed(fx_mask(sum[0], EFF_W));
			out_y <= $signed(fx_mask(sum[1], EFF_W));
			out_z <= three ? $signed(fx_mask(sum[2], EFF_W)) : 32'sd0;
			overflow <= lov[0] | lov[1] | (three & lov[2]);
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* bench/tb_polynomial_map_evaluator.sv */
// Testbench for polynomial_map_evaluator: coefficient writes, point evaluation over all
// dimension and order settings, checked against an in-bench Q8.24 predictor.
// Depends on pmev_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_polynomial_map_evaluator;
	import pmev_pkg::*;

	localparam int MAX_ORD = 6;
	localparam int N_TERMS = 84;
	localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               ov;
	} mapped_pt_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [2:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [0:0]         opcode;
	logic [1:0]         coef_row;
	logic [6:0]         coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               overflow;

	logic signed [31:0] coef_mem [0:2][0:N_TERMS-1];
	logic [1:0]         cur_dim;
	logic [2:0]         cur_order;
	mapped_pt_t         pending_pts[$];
	int                 errors;
	int                 n_evals;
	int                 n_writes;
	int                 n_ovf;
	bit                 quiet;
	bit                 long_hold;

	polynomial_map_evaluator dut (.*);

	always #10 clk = ~clk;

	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Q8.24 arithmetic
	function automatic logic signed [31:0] sat_q(input longint q, inout bit ov);
		if (q > 64'sd2147483647) begin
			ov = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (q < -64'sd2147483648) begin
			ov = 1'b1;
			return 32'sh8000_0000;
		end
		return q[31:0];
	endfunction

	function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
		input logic signed [31:0] b, inout bit ov);
		longint p;
		p = longint'(a) * longint'(b);
		return sat_q(p >>> 24, ov);
	endfunction

	function automatic logic signed [31:0] add_q(input logic signed [31:0] a,
		input logic signed [31:0] b, inout bit ov);
		return sat_q(longint'(a) + longint'(b), ov);
	endfunction

	function automatic logic signed [31:0] pow_q(input logic signed [31:0] b, input int e,
		inout bit ov);
		logic signed [31:0] r;
		r = Q_ONE;
		for (int n = 0; n < e; n++)
			r = mul_q(r, b, ov);
		return r;
	endfunction

	function automatic logic signed [31:0] quad_row(input int row, input bit three,
		input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z, inout bit ov);
		logic signed [31:0] acc;
		logic signed [31:0] t;
		mono_t m;
		int cnt;
		acc = 0;
		cnt = three ? FIXED_CNT_3D : FIXED_CNT_2D;
		for (int n = 0; n < cnt; n++) begin
			m = fixed_mono(three, n[3:0]);
			case (m)
				M_X: t = x;
				M_Y: t = y;
				M_Z: t = z;
				M_XX: t = mul_q(x, x, ov);
				M_YY: t = mul_q(y, y, ov);
				M_ZZ: t = mul_q(z, z, ov);
				M_XY: t = mul_q(x, y, ov);
				M_XZ: t = mul_q(x, z, ov);
				M_YZ: t = mul_q(y, z, ov);
				default: t = Q_ONE;
			endcase
			if (n == 0)
				acc = add_q(acc, coef_mem[row][0], ov);
			else
				acc = add_q(acc, mul_q(coef_mem[row][n], t, ov), ov);
		end
		return acc;
	endfunction

	function automatic logic signed [31:0] nested_row(input int row, input bit three,
		input int ord, input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z, inout bit ov);
		logic signed [31:0] acc;
		logic signed [31:0] t;
		int n;
		acc = 0;
		n = 0;
		for (int i = 0; i <= ord; i++)
			for (int j = 0; j + i <= ord; j++) begin
				if (!three) begin
					if (n < N_TERMS) begin
						t = mul_q(coef_mem[row][n], pow_q(x, j, ov), ov);
						t = mul_q(t, pow_q(y, i, ov), ov);
						acc = add_q(acc, t, ov);
					end
					n++;
				end else begin
					for (int k = 0; k + i + j <= ord; k++) begin
						if (n < N_TERMS) begin
							t = mul_q(coef_mem[row][n], pow_q(x, k, ov), ov);
							t = mul_q(t, pow_q(y, j, ov), ov);
							t = mul_q(t, pow_q(z, i, ov), ov);
							acc = add_q(acc, t, ov);
						end
						n++;
					end
				end
			end
		return acc;
	endfunction

	function automatic mapped_pt_t map_point(input logic signed [31:0] x,
		input logic signed [31:0] y, input logic signed [31:0] z);
		mapped_pt_t r;
		logic signed [31:0] v [0:2];
		bit three;
		bit ov;
		int ord;
		three = (cur_dim == DIM_3D);
		ord = (cur_order > MAX_ORD) ? MAX_ORD : cur_order;
		ov = 1'b0;
		if (!three)
			z = 0;
		v[2] = 0;
		for (int row = 0; row < (three ? 3 : 2); row++)
			v[row] = (ord == 2) ? quad_row(row, three, x, y, z, ov)
				: nested_row(row, three, ord, x, y, z, ov);
		r.x = v[0];
		r.y = v[1];
		r.z = v[2];
		r.ov = ov;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(0, 9))
			0: return $signed($urandom);
			1: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
			2: return ($urandom_range(0, 1)) ? Q_ONE : -Q_ONE;
			default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
		endcase
	endfunction

	// one request; leaves valid high so back-to-back requests need no gap
	task automatic send_req(input logic op, input logic [1:0] row, input logic [6:0] idx,
		input logic signed [31:0] val, input logic signed [31:0] x,
		input logic signed [31:0] y, input logic signed [31:0] z);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		coef_row <= row;
		coef_index <= idx;
		coef_value <= val;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		do @(posedge clk); while (in_stall);
		if (op == OP_WRITE) begin
			n_writes++;
			if (row < ROWS && idx < N_TERMS)
				coef_mem[row][idx] = val;
		end else begin
			n_evals++;
			pending_pts.push_back(map_point(x, y, z));
		end
		@(negedge clk);
	endtask

	task automatic write_coef(input logic [1:0] row, input logic [6:0] idx,
		input logic signed [31:0] val);
		send_req(OP_WRITE, row, idx, val, $signed($urandom), $signed($urandom),
			$signed($urandom));
	endtask

	task automatic eval_pt(input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z);
		send_req(OP_EVAL, 2'($urandom), 7'($urandom), $signed($urandom), x, y, z);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_pts.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic set_mode(input logic [1:0] dim, input logic [2:0] ord);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_DIMENSION;
		cfg_data <= {1'b0, dim};
		@(negedge clk);
		cfg_index <= CFG_POLY_ORDER;
		cfg_data <= ord;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_dim = dim;
		cur_order = ord;
	endtask

	task automatic test_fill_store();
		for (int r = 0; r < ROWS; r++)
			for (int i = 0; i < N_TERMS; i++)
				write_coef(2'(r), 7'(i),
					$signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
	endtask

	task automatic test_directed();
		set_mode(2'd2, 3'd2);
		eval_pt(0, 0, 0);
		eval_pt(Q_ONE, -Q_ONE, 0);
		eval_pt(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		write_coef(2'd3, 7'd5, 32'sh7fff_ffff);
		write_coef(2'd1, 7'd127, 32'sh8000_0000);
		write_coef(2'd0, 7'd84, -1);
		write_coef(2'd0, 7'd0, 32'sh7fff_ffff);
		write_coef(2'd0, 7'd1, 32'sh7fff_ffff);
		eval_pt(Q_ONE, Q_ONE, Q_ONE);
		write_coef(2'd0, 7'd0, 32'sh8000_0000);
		eval_pt(-Q_ONE, 32'sh8000_0000, 0);
		set_mode(2'd3, 3'd2);
		eval_pt(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
		eval_pt(Q_ONE, Q_ONE, -Q_ONE);
		set_mode(2'd3, 3'd0);
		eval_pt(Q_ONE, Q_ONE, Q_ONE);
		set_mode(2'd3, 3'd7);
		eval_pt(Q_ONE >>> 1, -(Q_ONE >>> 1), Q_ONE);
		eval_pt(32'sh7fff_ffff, Q_ONE, Q_ONE);
		set_mode(2'd0, 3'd6);
		eval_pt(Q_ONE, -Q_ONE, 32'sh7fff_ffff);
		set_mode(2'd1, 3'd1);
		eval_pt(32'sh7fff_ffff, 32'sh7fff_ffff, 0);
		write_coef(2'd0, 7'd0, Q_ONE);
		write_coef(2'd0, 7'd1, -Q_ONE);
	endtask

	task automatic test_backpressure();
		set_mode(2'd3, 3'd1);
		long_hold = 1'b1;
		quiet = 1'b1;
		for (int n = 0; n < 8; n++) begin
			eval_pt(rand_q(), rand_q(), rand_q());
			write_coef(2'($urandom_range(0, 2)), 7'($urandom_range(0, N_TERMS - 1)),
				rand_q());
		end
		long_hold = 1'b0;
		quiet = 1'b0;
	endtask

	task automatic test_random();
		logic [1:0] dims [12] = '{2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
			2'd2, 2'd3, 2'd3};
		logic [2:0] ords [12] = '{3'd2, 3'd2, 3'd6, 3'd6, 3'd0, 3'd7, 3'd1, 3'd3, 3'd4,
			3'd5, 3'd1, 3'd3};
		int pick;
		for (int ph = 0; ph < 12; ph++) begin
			set_mode(dims[ph], ords[ph]);
			quiet = (ph % 4 == 1);
			for (int n = 0; n < 45; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					eval_pt(rand_q(), rand_q(), rand_q());
				else if (pick < 9)
					write_coef(2'($urandom_range(0, 2)),
						7'($urandom_range(0, N_TERMS - 1)), rand_q());
				else
					write_coef(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
						rand_q());
			end
		end
		quiet = 1'b0;
	endtask

	// receiver: random hold-off per result, a long hold per result while asked
	initial begin
		int n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = long_hold ? 300 : (quiet ? 0 : $urandom_range(0, 7));
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		mapped_pt_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pts.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h ov=%b", $realtime,
					out_x, out_y, out_z, overflow);
				errors++;
			end else begin
				e = pending_pts.pop_front();
				if (overflow)
					n_ovf++;
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z || overflow !== e.ov) begin
					$display("%0t: mismatch exp x=%h y=%h z=%h ov=%b got x=%h y=%h z=%h ov=%b",
						$realtime, e.x, e.y, e.z, e.ov, out_x, out_y, out_z, overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DIMENSION;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_WRITE;
		coef_row = '0;
		coef_index = '0;
		coef_value = '0;
		in_x = '0;
		in_y = '0;
		in_z = '0;
		errors = 0;
		n_evals = 0;
		n_writes = 0;
		n_ovf = 0;
		quiet = 1'b0;
		long_hold = 1'b0;
		cur_dim = 2'd2;
		cur_order = 3'd2;
		for (int r = 0; r < ROWS; r++)
			for (int i = 0; i < N_TERMS; i++)
				coef_mem[r][i] = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_fill_store();
		test_directed();
		test_backpressure();
		test_random();
		settle();
		$display("Covered %0d evaluate and %0d write requests, %0d results saturated,",
			n_evals, n_writes, n_ovf);
		$display("over 2-D and 3-D maps of order 0 to 7, including ignored writes.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/pmev_pkg.sv
hw/rtl/pmev_ram.sv
hw/rtl/pmev_lane.sv
hw/rtl/pmev_ctrl.sv
hw/rtl/polynomial_map_evaluator.sv
bench/tb_polynomial_map_evaluator.sv
